// ----- hdl/ctt_pkg.sv -----
// Shared types and constants for the callback timer table.
package ctt_pkg;

    localparam int ADDR_W = 48;
    localparam int REP_W  = 16;
    localparam int SLOT_W = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    typedef struct packed {
        logic arm;
        logic start;
        logic eval;
        logic adv;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic cur_valid;
        logic cur_pend;
        logic idx_last;
        logic held_v;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/ctt_in_if.sv -----
// Input channel of the callback timer table: arm and tick words.
interface ctt_in_if #(
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [3:0]           slot;
    logic [47:0]          callback_addr;
    logic [TIME_BITS-1:0] wait_time;
    logic [15:0]          repeat_count;
    logic                 repeat_forever;
    logic [TIME_BITS-1:0] delta_time;

    modport source (
        output valid, cmd, slot, callback_addr, wait_time, repeat_count,
               repeat_forever, delta_time,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, callback_addr, wait_time, repeat_count,
               repeat_forever, delta_time,
        output ready
    );
endinterface

// ----- hdl/ctt_out_if.sv -----
// Output channel of the callback timer table: fire report words.
interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic        fired;
    logic [3:0]  fired_slot;
    logic [47:0] fired_addr;
    logic        last;

    modport source (
        output valid, fired, fired_slot, fired_addr, last,
        input  ready
    );
    modport sink (
        input  valid, fired, fired_slot, fired_addr, last,
        output ready
    );
endinterface

// ----- hdl/callback_timer_table.sv -----
// Top level of the callback timer table: controller and datapath.
// Arm word: accepted while idle, no result.
// Tick word: walks slots in order; a free slot is passed over in the read state, an armed
// slot is read and then evaluated, and the walk ends by emitting the last word; it stalls
// while the output register is busy.
// Reset clears the valid and pending bits and control; slot fields are written by arm.
module callback_timer_table import ctt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctt_in_if.sink        i_in,
    ctt_out_if.source     o_out
);

    t_cmd  cmd;
    t_stat stat;

    ctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ctt_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_slot           (i_in.slot),
        .i_callback_addr  (i_in.callback_addr),
        .i_wait_time      (i_in.wait_time),
        .i_repeat_count   (i_in.repeat_count),
        .i_repeat_forever (i_in.repeat_forever),
        .i_delta_time     (i_in.delta_time),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_fired          (o_out.fired),
        .o_fired_slot     (o_out.fired_slot),
        .o_fired_addr     (o_out.fired_addr),
        .o_last           (o_out.last)
    );

endmodule

// ----- hdl/ctt_dp.sv -----
// Datapath of the callback timer table: slot store, walk index, held fire and output register.
module ctt_dp import ctt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [ADDR_W-1:0]    i_callback_addr,
    input  logic [TIME_BITS-1:0] i_wait_time,
    input  logic [REP_W-1:0]     i_repeat_count,
    input  logic                 i_repeat_forever,
    input  logic [TIME_BITS-1:0] i_delta_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_fired,
    output logic [SLOT_W-1:0]    o_fired_slot,
    output logic [ADDR_W-1:0]    o_fired_addr,
    output logic                 o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ADDR_W-1:0]    mem_addr    [SLOTS];
    logic [TIME_BITS-1:0] mem_wait    [SLOTS];
    logic [TIME_BITS-1:0] mem_elapsed [SLOTS];
    logic [REP_W-1:0]     mem_rep     [SLOTS];
    logic                 mem_forever [SLOTS];

    logic [ADDR_W-1:0]    r_rd_addr;
    logic [TIME_BITS-1:0] r_rd_wait;
    logic [TIME_BITS-1:0] r_rd_elapsed;
    logic [REP_W-1:0]     r_rd_rep;
    logic                 r_rd_forever;

    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     r_pend;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_delta;

    logic                 r_h_v;
    logic [SLOT_W-1:0]    r_h_slot;
    logic [ADDR_W-1:0]    r_h_addr;

    logic                 r_o_v;
    logic                 r_o_fired;
    logic [SLOT_W-1:0]    r_o_slot;
    logic [ADDR_W-1:0]    r_o_addr;
    logic                 r_o_last;

    logic                 arm_ok;
    logic [IDX_W-1:0]     arm_idx;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] sat_sum;
    logic                 out_free;
    logic                 cur_pend;
    logic                 ev_fire;
    logic                 ev_reload;
    logic                 ev_dec;
    logic                 ev_wr_elapsed;
    logic [TIME_BITS-1:0] ev_elapsed;

    assign arm_ok   = ({4'b0, i_slot} < 8'(SLOTS));
    assign arm_idx  = IDX_W'(i_slot);
    assign out_free = !r_o_v || i_ready;
    assign cur_pend = r_pend[r_idx];

    assign sum     = {1'b0, r_rd_elapsed} + {1'b0, r_delta};
    assign sat_sum = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    always_comb begin
        ev_fire       = i_cmd.eval && cur_pend;
        ev_reload     = ev_fire && (r_rd_forever || (r_rd_rep != '0));
        ev_dec        = ev_fire && !r_rd_forever && (r_rd_rep != '0);
        ev_wr_elapsed = 1'b0;
        ev_elapsed    = '0;
        if (i_cmd.eval) begin
            if (cur_pend) begin
                ev_wr_elapsed = ev_reload;
            end else if (r_rd_elapsed < r_rd_wait) begin
                ev_wr_elapsed = 1'b1;
                ev_elapsed    = sat_sum;
            end
        end
    end

    // slot store: one write port, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm && arm_ok) begin
            mem_addr[arm_idx]    <= i_callback_addr;
            mem_wait[arm_idx]    <= i_wait_time;
            mem_elapsed[arm_idx] <= '0;
            mem_rep[arm_idx]     <= i_repeat_count;
            mem_forever[arm_idx] <= i_repeat_forever;
        end else begin
            if (ev_wr_elapsed) begin
                mem_elapsed[r_idx] <= ev_elapsed;
            end
            if (ev_dec) begin
                mem_rep[r_idx] <= r_rd_rep - REP_W'(1);
            end
        end
        r_rd_addr    <= mem_addr[r_idx];
        r_rd_wait    <= mem_wait[r_idx];
        r_rd_elapsed <= mem_elapsed[r_idx];
        r_rd_rep     <= mem_rep[r_idx];
        r_rd_forever <= mem_forever[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pend  <= '0;
            r_idx   <= '0;
            r_h_v   <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (i_cmd.arm && arm_ok) begin
                r_valid[arm_idx] <= 1'b1;
                r_pend[arm_idx]  <= 1'b0;
            end
            if (i_cmd.eval) begin
                if (cur_pend) begin
                    r_pend[r_idx] <= 1'b0;
                    if (!ev_reload) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                end else if (r_rd_elapsed >= r_rd_wait) begin
                    r_pend[r_idx] <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if (i_cmd.adv) begin
                r_idx <= r_idx + IDX_W'(1);
            end

            if (i_ready) begin
                r_o_v <= 1'b0;
            end
            if (ev_fire && r_h_v) begin
                r_o_v <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_o_v <= 1'b1;
            end

            if (i_cmd.start || i_cmd.flush) begin
                r_h_v <= 1'b0;
            end else if (ev_fire) begin
                r_h_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_delta <= i_delta_time;
        end
        if (ev_fire) begin
            r_h_slot <= SLOT_W'(r_idx);
            r_h_addr <= r_rd_addr;
        end
        if (ev_fire && r_h_v) begin
            r_o_fired <= 1'b1;
            r_o_slot  <= r_h_slot;
            r_o_addr  <= r_h_addr;
            r_o_last  <= 1'b0;
        end else if (i_cmd.flush) begin
            r_o_fired <= r_h_v;
            r_o_slot  <= r_h_v ? r_h_slot : '0;
            r_o_addr  <= r_h_v ? r_h_addr : '0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_stat.cur_valid = r_valid[r_idx];
    assign o_stat.cur_pend  = cur_pend;
    assign o_stat.idx_last  = (r_idx == IDX_W'(SLOTS - 1));
    assign o_stat.held_v    = r_h_v;
    assign o_stat.out_free  = out_free;

    assign o_valid      = r_o_v;
    assign o_fired      = r_o_fired;
    assign o_fired_slot = r_o_slot;
    assign o_fired_addr = r_o_addr;
    assign o_last       = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_fire && r_h_v) |-> out_free)
        else $error("held fire pushed into a busy output register");

    a_flush_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> out_free)
        else $error("final word pushed into a busy output register");

    a_arm_vs_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.arm |-> !(i_cmd.eval || i_cmd.adv || i_cmd.flush))
        else $error("arm overlaps a tick walk");

    a_flush_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_h_v && r_o_v && r_o_last)
        else $error("tick did not end with a last word");

endmodule

// ----- hdl/ctt_ctrl.sv -----
// Controller of the callback timer table: accepts words and sequences the slot walk.
module ctt_ctrl import ctt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_cmd,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_ARM) begin
                        o_cmd.arm = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_stat.cur_valid) begin
                    n_state = S_EV;
                end else if (i_stat.idx_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_EV: begin
                if (!(i_stat.cur_pend && i_stat.held_v && !i_stat.out_free)) begin
                    o_cmd.eval = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_tick_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_RD)
        else $error("tick accepted without starting the walk");

endmodule

// ----- dv/tb_callback_timer_table.sv -----
// Testbench for callback_timer_table: directed and random arm/tick words, scoreboard check.
module tb_callback_timer_table;
    import ctt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;

    typedef struct {
        logic        cmd;
        logic [3:0]  slot;
        logic [47:0] addr;
        logic [31:0] wait_len;
        logic [15:0] reps;
        logic        rpt_forever;
        logic [31:0] delta;
    } t_word;

    typedef struct {
        logic        fired;
        logic [3:0]  slot;
        logic [47:0] addr;
        logic        last;
    } t_report;

    class fire_scoreboard;
        bit          valid_q[NSLOT];
        bit          pend_q[NSLOT];
        bit          fore_q[NSLOT];
        logic [15:0] reps_left[NSLOT];
        logic [31:0] elapsed[NSLOT];
        logic [31:0] wait_len[NSLOT];
        logic [47:0] addr_q[NSLOT];
        t_report     fire_q[$];
        int          n_arms, n_ticks, n_fires, n_quiet, n_checked, n_errors;

        function int outstanding();
            return fire_q.size();
        endfunction

        // Walk the table for one tick and queue the report words it causes, the last one marked last.
        function void walk_tick(logic [31:0] delta);
            t_report  held;
            bit       have;
            logic [32:0] sum;
            have = 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!valid_q[i]) continue;
                if (pend_q[i]) begin
                    if (have) fire_q.push_back(held);
                    held = '{1'b1, 4'(i), addr_q[i], 1'b0};
                    have = 1'b1;
                    n_fires++;
                    pend_q[i] = 1'b0;
                    if (fore_q[i]) begin
                        elapsed[i] = '0;
                    end else if (reps_left[i] != 0) begin
                        reps_left[i] = reps_left[i] - 16'd1;
                        elapsed[i] = '0;
                    end else begin
                        valid_q[i] = 1'b0;
                    end
                    continue;
                end
                if (elapsed[i] >= wait_len[i]) begin
                    pend_q[i] = 1'b1;
                    continue;
                end
                sum = {1'b0, elapsed[i]} + {1'b0, delta};
                elapsed[i] = sum[32] ? '1 : sum[31:0];
            end
            if (have) begin
                held.last = 1'b1;
                fire_q.push_back(held);
            end else begin
                fire_q.push_back('{1'b0, 4'd0, 48'd0, 1'b1});
                n_quiet++;
            end
        endfunction

        function void note_input(t_word w);
            if (w.cmd == CMD_ARM) begin
                n_arms++;
                valid_q[w.slot]   = 1'b1;
                pend_q[w.slot]    = 1'b0;
                addr_q[w.slot]    = w.addr;
                wait_len[w.slot]  = w.wait_len;
                reps_left[w.slot] = w.reps;
                fore_q[w.slot]    = w.rpt_forever;
                elapsed[w.slot]   = '0;
            end else begin
                n_ticks++;
                walk_tick(w.delta);
            end
        endfunction

        function void check_result(t_report got);
            t_report exp;
            if (fire_q.size() == 0) begin
                n_errors++;
                $display("%t unexpected word: fired=%0b slot=%0d addr=%h last=%0b",
                         $realtime, got.fired, got.slot, got.addr, got.last);
                return;
            end
            exp = fire_q.pop_front();
            n_checked++;
            if (got.fired !== exp.fired || got.slot !== exp.slot ||
                got.addr !== exp.addr || got.last !== exp.last) begin
                n_errors++;
                $display("%t mismatch: exp fired=%0b slot=%0d addr=%h last=%0b",
                         $realtime, exp.fired, exp.slot, exp.addr, exp.last);
                $display("%t           got fired=%0b slot=%0d addr=%h last=%0b",
                         $realtime, got.fired, got.slot, got.addr, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;

    fire_scoreboard board;

    ctt_in_if #(.TIME_BITS(32)) in_if ();
    ctt_out_if                  out_if ();

    callback_timer_table #(.SLOTS(NSLOT), .TIME_BITS(32)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4ns i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(t_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.cmd            <= w.cmd;
        in_if.slot           <= w.slot;
        in_if.callback_addr  <= w.addr;
        in_if.wait_time      <= w.wait_len;
        in_if.repeat_count   <= w.reps;
        in_if.repeat_forever <= w.rpt_forever;
        in_if.delta_time     <= w.delta;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_input(w);
    endtask

    task automatic arm_slot(logic [3:0] s, logic [47:0] a, logic [31:0] wt,
                            logic [15:0] reps, logic fore);
        send_word('{CMD_ARM, s, a, wt, reps, fore, $urandom});
    endtask

    task automatic tick(logic [31:0] delta);
        send_word('{CMD_TICK, 4'($urandom), 48'({$urandom, $urandom}),
                    $urandom, 16'($urandom), 1'($urandom), delta});
    endtask

    function automatic logic [31:0] rand_wait();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 70) return $urandom_range(1, 32'h0004_0000);
        if (r < 90) return $urandom;
        return '1;
    endfunction

    function automatic logic [31:0] rand_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 75) return $urandom_range(0, 32'h0002_0000);
        if (r < 90) return $urandom;
        return '1;
    endfunction

    function automatic logic [15:0] rand_reps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 3));
        if (r < 80) return 16'($urandom_range(0, 20));
        return 16'($urandom_range(0, 65535));
    endfunction

    // receiver: random stalls plus one long hold-off to back the table up
    initial begin : sink
        int  gap;
        bit  held;
        held = 1'b0;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && board.n_checked >= 40) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            board.check_result('{out_if.fired, out_if.fired_slot,
                                 out_if.fired_addr, out_if.last});
        end
    end

    initial begin : stim
        board = new();
        calm  = 1'b0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.cmd            <= CMD_TICK;
        in_if.slot           <= '0;
        in_if.callback_addr  <= '0;
        in_if.wait_time      <= '0;
        in_if.repeat_count   <= '0;
        in_if.repeat_forever <= 1'b0;
        in_if.delta_time     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        tick('0);
        arm_slot(4'd0, '1, '0, '0, 1'b0);
        tick('1);
        tick('0);
        tick(32'd5);
        arm_slot(4'd15, '0, '1, '1, 1'b0);
        arm_slot(4'd1, 48'h5555_5555_5555, 32'd1, 16'd2, 1'b0);
        arm_slot(4'd2, 48'hAAAA_AAAA_AAAA, 32'h0001_0000, 16'd0, 1'b1);
        tick('1);
        tick(32'd1);
        tick('0);
        arm_slot(4'd1, 48'h1234_5678_9ABC, 32'd2, 16'd0, 1'b0);
        tick(32'd2);
        tick('0);
        tick('0);
        arm_slot(4'd7, 48'h8000_0000_0001, 32'h8000_0000, '1, 1'b1);
        tick(32'h7FFF_FFFF);
        tick(32'h7FFF_FFFF);
        tick('0);
        tick('0);
        tick(32'h0000_8000);

        // random
        for (int k = 0; k < 240; k++) begin
            calm = (k >= 100 && k < 140);
            if ($urandom_range(0, 99) < 35)
                arm_slot(4'($urandom), 48'({$urandom, $urandom}),
                         rand_wait(), rand_reps(), $urandom_range(0, 4) == 0);
            else
                tick(rand_delta());
        end
        calm = 1'b0;
        in_if.valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d arm words and %0d ticks: %0d fire reports, %0d quiet ticks.",
                 board.n_arms, board.n_ticks, board.n_fires, board.n_quiet);
        $display("Included saturation, repeat and forever reloads, overwrites, long stall.");
        if (board.n_errors == 0 && board.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ctt_pkg.sv
hdl/ctt_in_if.sv
hdl/ctt_out_if.sv
hdl/ctt_dp.sv
hdl/ctt_ctrl.sv
hdl/callback_timer_table.sv
dv/tb_callback_timer_table.sv
